FILE: hdl/reachability_watchdog_power_cycler_defines.svh
// Assertion macros shared by the watchdog RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef REACHABILITY_WATCHDOG_POWER_CYCLER_DEFINES_SVH
`define REACHABILITY_WATCHDOG_POWER_CYCLER_DEFINES_SVH
`ifndef ASSERT_OFF
`define RWPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RWPC_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define RWPC_ASSERT(lbl, prop, msg)
`define RWPC_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

FILE: hdl/rwpc_pkg.sv
package rwpc_pkg;

	localparam int TICKS_PER_SECOND = 1000;
	localparam int TIME_W = 32;
	localparam int SEC_W = 16;
	localparam int TICK_W = SEC_W + $clog2(TICKS_PER_SECOND);
	localparam int CMP_W = (TICK_W > TIME_W) ? TICK_W : TIME_W;

	// Holdoff elapsed time is always below the holdoff tick count.
	localparam int HOLD_D_W = (TICK_W < TIME_W) ? TICK_W : TIME_W;
	// Reciprocal of the tick rate, scaled so that the product is exact over HOLD_D_W bits.
	localparam int DIV_SHIFT = HOLD_D_W + $clog2(TICKS_PER_SECOND);
	localparam int DIV_MUL_W = DIV_SHIFT - $clog2(TICKS_PER_SECOND) + 1;
	localparam longint unsigned DIV_MUL =
		((64'd1 << DIV_SHIFT) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND);
	localparam int HOLD_PROD_W = HOLD_D_W + DIV_MUL_W;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MODE_W = 2;
	localparam int HEALTH_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_INTERVAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAIL_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_OFF = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_PRESENT = 3'd5;

	localparam logic [MODE_W-1:0] MODE_PLUG = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NET = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DEV = 2'd2;

	localparam logic [HEALTH_W-1:0] HEALTH_UNKNOWN = 2'd0;
	localparam logic [HEALTH_W-1:0] HEALTH_OK = 2'd1;
	localparam logic [HEALTH_W-1:0] HEALTH_FAIL = 2'd2;

	localparam logic CMD_STEP = 1'b0;
	localparam logic CMD_RESET = 1'b1;

	localparam int RST_PROBE_S = 5;
	localparam int RST_FAIL_S = 180;
	localparam int RST_OFF_S = 5;
	localparam int RST_HOLDOFF_S = 180;

	localparam logic [TICK_W-1:0] RST_PROBE_TICKS = TICK_W'(64'(RST_PROBE_S) * TICKS_PER_SECOND);
	localparam logic [TICK_W-1:0] RST_FAIL_TICKS = TICK_W'(64'(RST_FAIL_S) * TICKS_PER_SECOND);
	localparam logic [TICK_W-1:0] RST_OFF_TICKS = TICK_W'(64'(RST_OFF_S) * TICKS_PER_SECOND);
	localparam logic [TICK_W-1:0] RST_HOLD_TICKS =
		TICK_W'(64'(RST_HOLDOFF_S) * TICKS_PER_SECOND);

	typedef enum logic [1:0] {
		HOLD_KEEP,
		HOLD_SET,
		HOLD_CLEAR
	} hold_op_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic target_present;
		logic [SEC_W-1:0] holdoff_s;
		logic [TICK_W-1:0] probe_ticks;
		logic [TICK_W-1:0] fail_ticks;
		logic [TICK_W-1:0] off_ticks;
		logic [TICK_W-1:0] hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic relay_drive;
		logic [HEALTH_W-1:0] health;
		logic holding_off;
		logic [SEC_W-1:0] incident_count;
		logic trigger_pulse;
		logic probe_used;
		hold_op_t hold_op;
		logic [HOLD_D_W-1:0] hold_d;
	} step_res_t;

	// Wrapped elapsed time against a tick threshold, compared at full width.
	function automatic logic reached(input logic [TIME_W-1:0] d, input logic [TICK_W-1:0] t);
		return CMP_W'(d) >= CMP_W'(t);
	endfunction

endpackage

FILE: hdl/rwpc_item_if.sv
interface rwpc_item_if;
	logic valid;
	logic ready;
	logic command;
	logic [rwpc_pkg::TIME_W-1:0] now_ms;
	logic probe_ok;

	modport source (output valid, output command, output now_ms, output probe_ok, input ready);
	modport sink (input valid, input command, input now_ms, input probe_ok, output ready);
endinterface

FILE: hdl/rwpc_result_if.sv
interface rwpc_result_if;
	logic valid;
	logic ready;
	logic relay_drive;
	logic [rwpc_pkg::HEALTH_W-1:0] health;
	logic holding_off;
	logic [rwpc_pkg::SEC_W-1:0] holdoff_left_s;
	logic [rwpc_pkg::SEC_W-1:0] incident_count;
	logic trigger_pulse;
	logic probe_used;

	modport source (output valid, output relay_drive, output health, output holding_off,
		output holdoff_left_s, output incident_count, output trigger_pulse,
		output probe_used, input ready);
	modport sink (input valid, input relay_drive, input health, input holding_off,
		input holdoff_left_s, input incident_count, input trigger_pulse,
		input probe_used, output ready);
endinterface

FILE: hdl/rwpc_cfg_if.sv
interface rwpc_cfg_if;
	logic valid;
	logic ready;
	logic [rwpc_pkg::CFG_IDX_W-1:0] index;
	logic [rwpc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/rwpc_cfg.sv
module rwpc_cfg (
	input logic clk,
	input logic arst_n,
	rwpc_cfg_if.sink cfg,
	output rwpc_pkg::cfg_t cfg_regs
);

	rwpc_pkg::cfg_t cfg_q;
	logic [rwpc_pkg::TICK_W-1:0] wr_ticks;

	// Seconds are turned into ticks once, when the register is written.
	assign wr_ticks = rwpc_pkg::TICK_W'(cfg.data[rwpc_pkg::SEC_W-1:0])
		* rwpc_pkg::TICK_W'(rwpc_pkg::TICKS_PER_SECOND);

	assign cfg.ready = 1'b1;
	assign cfg_regs = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= rwpc_pkg::MODE_PLUG;
			cfg_q.target_present <= 1'b0;
			cfg_q.holdoff_s <= rwpc_pkg::SEC_W'(rwpc_pkg::RST_HOLDOFF_S);
			cfg_q.probe_ticks <= rwpc_pkg::RST_PROBE_TICKS;
			cfg_q.fail_ticks <= rwpc_pkg::RST_FAIL_TICKS;
			cfg_q.off_ticks <= rwpc_pkg::RST_OFF_TICKS;
			cfg_q.hold_ticks <= rwpc_pkg::RST_HOLD_TICKS;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rwpc_pkg::REG_MODE: cfg_q.mode <= cfg.data[rwpc_pkg::MODE_W-1:0];
				rwpc_pkg::REG_PROBE_INTERVAL: cfg_q.probe_ticks <= wr_ticks;
				rwpc_pkg::REG_FAIL_THRESHOLD: cfg_q.fail_ticks <= wr_ticks;
				rwpc_pkg::REG_POWER_OFF: cfg_q.off_ticks <= wr_ticks;
				rwpc_pkg::REG_HOLDOFF: begin
					cfg_q.holdoff_s <= cfg.data[rwpc_pkg::SEC_W-1:0];
					cfg_q.hold_ticks <= wr_ticks;
				end
				rwpc_pkg::REG_TARGET_PRESENT: cfg_q.target_present <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

FILE: hdl/rwpc_step.sv
`include "reachability_watchdog_power_cycler_defines.svh"

module rwpc_step (
	input logic clk,
	input logic arst_n,
	rwpc_item_if.sink item,
	input rwpc_pkg::cfg_t cfg_regs,
	input logic ready_s2,
	output logic valid_s2,
	output rwpc_pkg::step_res_t res_s2
);

	logic valid_s1;
	logic command_s1;
	logic [rwpc_pkg::TIME_W-1:0] now_s1;
	logic probe_ok_s1;
	logic adv_s1;

	logic [rwpc_pkg::TIME_W-1:0] last_probe_q, fail_start_q, hold_start_q, off_start_q;
	logic fail_timing_q, cycle_active_q, off_issued_q, in_holdoff_q, relay_q;
	logic [rwpc_pkg::HEALTH_W-1:0] health_q;
	logic [rwpc_pkg::SEC_W-1:0] incidents_q;

	logic [rwpc_pkg::TIME_W-1:0] last_probe_d, fail_start_d, hold_start_d, off_start_d;
	logic fail_timing_d, cycle_active_d, off_issued_d, in_holdoff_d, relay_d;
	logic [rwpc_pkg::HEALTH_W-1:0] health_d;
	logic [rwpc_pkg::SEC_W-1:0] incidents_d;
	logic trig, used, take_probe;
	rwpc_pkg::hold_op_t hold_op;
	logic [rwpc_pkg::TIME_W-1:0] d_off, d_hold, d_probe, fs;

	assign adv_s1 = valid_s1 && (!valid_s2 || ready_s2);
	assign item.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			command_s1 <= item.command;
			now_s1 <= item.now_ms;
			probe_ok_s1 <= item.probe_ok;
		end
	end

	assign d_off = now_s1 - off_start_q;
	assign d_hold = now_s1 - hold_start_q;
	assign d_probe = now_s1 - last_probe_q;

	always_comb begin
		last_probe_d = last_probe_q;
		fail_start_d = fail_start_q;
		hold_start_d = hold_start_q;
		off_start_d = off_start_q;
		fail_timing_d = fail_timing_q;
		cycle_active_d = cycle_active_q;
		off_issued_d = off_issued_q;
		in_holdoff_d = in_holdoff_q;
		relay_d = relay_q;
		health_d = health_q;
		incidents_d = incidents_q;
		trig = 1'b0;
		used = 1'b0;
		take_probe = 1'b0;
		hold_op = rwpc_pkg::HOLD_KEEP;
		fs = now_s1;

		if (command_s1 == rwpc_pkg::CMD_RESET) begin
			fail_timing_d = 1'b0;
			incidents_d = '0;
		end else if (cycle_active_q) begin
			if (!off_issued_q) begin
				relay_d = 1'b0;
				off_issued_d = 1'b1;
				off_start_d = now_s1;
			end else if (rwpc_pkg::reached(d_off, cfg_regs.off_ticks)) begin
				relay_d = 1'b1;
				in_holdoff_d = 1'b1;
				hold_start_d = now_s1;
				cycle_active_d = 1'b0;
				off_issued_d = 1'b0;
			end
		end else if (in_holdoff_q && !rwpc_pkg::reached(d_hold, cfg_regs.hold_ticks)) begin
			hold_op = rwpc_pkg::HOLD_SET;
		end else begin
			if (in_holdoff_q) begin
				in_holdoff_d = 1'b0;
				hold_op = rwpc_pkg::HOLD_CLEAR;
				fail_timing_d = 1'b0;
			end
			if (rwpc_pkg::reached(d_probe, cfg_regs.probe_ticks)) begin
				last_probe_d = now_s1;
				unique case (cfg_regs.mode)
					rwpc_pkg::MODE_PLUG: health_d = rwpc_pkg::HEALTH_OK;
					rwpc_pkg::MODE_NET: take_probe = 1'b1;
					rwpc_pkg::MODE_DEV: take_probe = cfg_regs.target_present;
					default: ;
				endcase
			end
			if (take_probe) begin
				used = 1'b1;
				if (probe_ok_s1) begin
					health_d = rwpc_pkg::HEALTH_OK;
					fail_timing_d = 1'b0;
				end else begin
					health_d = rwpc_pkg::HEALTH_FAIL;
					fs = fail_timing_d ? fail_start_q : now_s1;
					fail_start_d = fs;
					if (rwpc_pkg::reached(now_s1 - fs, cfg_regs.fail_ticks)) begin
						cycle_active_d = 1'b1;
						if (incidents_q != '1) begin
							incidents_d = incidents_q + 1'b1;
						end
						fail_timing_d = 1'b0;
						trig = 1'b1;
					end else begin
						fail_timing_d = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_probe_q <= '0;
			fail_start_q <= '0;
			hold_start_q <= '0;
			off_start_q <= '0;
			fail_timing_q <= 1'b0;
			cycle_active_q <= 1'b0;
			off_issued_q <= 1'b0;
			in_holdoff_q <= 1'b0;
			relay_q <= 1'b1;
			health_q <= rwpc_pkg::HEALTH_UNKNOWN;
			incidents_q <= '0;
		end else if (adv_s1) begin
			last_probe_q <= last_probe_d;
			fail_start_q <= fail_start_d;
			hold_start_q <= hold_start_d;
			off_start_q <= off_start_d;
			fail_timing_q <= fail_timing_d;
			cycle_active_q <= cycle_active_d;
			off_issued_q <= off_issued_d;
			in_holdoff_q <= in_holdoff_d;
			relay_q <= relay_d;
			health_q <= health_d;
			incidents_q <= incidents_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (ready_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2.relay_drive <= relay_d;
			res_s2.health <= health_d;
			res_s2.holding_off <= in_holdoff_d;
			res_s2.incident_count <= incidents_d;
			res_s2.trigger_pulse <= trig;
			res_s2.probe_used <= used;
			res_s2.hold_op <= hold_op;
			res_s2.hold_d <= d_hold[rwpc_pkg::HOLD_D_W-1:0];
		end
	end

	`RWPC_ASSERT_NEVER(a_off_without_cycle, off_issued_q && !cycle_active_q, "off outside a cycle")
	`RWPC_ASSERT_NEVER(a_cycle_in_holdoff, cycle_active_q && in_holdoff_q, "cycle during holdoff")
	`RWPC_ASSERT_NEVER(a_relay_open, !relay_q && !off_issued_q, "relay open, no restore due")
	`RWPC_ASSERT(a_trig_starts_cycle, valid_s2 && res_s2.trigger_pulse |-> cycle_active_q, "no cycle")

endmodule

FILE: hdl/rwpc_holdoff.sv
module rwpc_holdoff (
	input logic clk,
	input logic arst_n,
	input rwpc_pkg::cfg_t cfg_regs,
	input logic valid_s2,
	input rwpc_pkg::step_res_t res_s2,
	output logic ready_s2,
	rwpc_result_if.source result
);

	logic [rwpc_pkg::HOLD_PROD_W-1:0] prod;
	logic [rwpc_pkg::SEC_W-1:0] secs;
	logic [rwpc_pkg::SEC_W-1:0] left_set;
	logic [rwpc_pkg::SEC_W-1:0] holdoff_left_q;
	logic [rwpc_pkg::SEC_W-1:0] holdoff_left_d;
	logic out_valid_q;
	logic load;

	// Whole seconds elapsed, by multiplying with the scaled reciprocal of the tick rate.
	assign prod = rwpc_pkg::HOLD_PROD_W'(res_s2.hold_d)
		* rwpc_pkg::HOLD_PROD_W'(rwpc_pkg::DIV_MUL[rwpc_pkg::DIV_MUL_W-1:0]);
	assign secs = prod[rwpc_pkg::DIV_SHIFT +: rwpc_pkg::SEC_W];
	assign left_set = cfg_regs.holdoff_s - secs;

	assign ready_s2 = !out_valid_q || result.ready;
	assign load = valid_s2 && ready_s2;

	always_comb begin
		case (res_s2.hold_op)
			rwpc_pkg::HOLD_SET: holdoff_left_d = left_set;
			rwpc_pkg::HOLD_CLEAR: holdoff_left_d = '0;
			default: holdoff_left_d = holdoff_left_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				holdoff_left_q <= holdoff_left_d;
			end
			if (ready_s2) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result.relay_drive <= res_s2.relay_drive;
			result.health <= res_s2.health;
			result.holding_off <= res_s2.holding_off;
			result.holdoff_left_s <= holdoff_left_d;
			result.incident_count <= res_s2.incident_count;
			result.trigger_pulse <= res_s2.trigger_pulse;
			result.probe_used <= res_s2.probe_used;
		end
	end

	assign result.valid = out_valid_q;

endmodule

FILE: hdl/reachability_watchdog_power_cycler.sv
// A request goes through the step stage, the stage hand-off and the output register.
// One request per clock while results are taken, set by the single state-update stage.
// A waiting result holds up the input only once both stages behind it are full as well,
// so up to three requests can be in flight.
// Reset (arst_n low, asynchronous) empties the pipeline, closes the relay, clears all
// timers, flags and counters and loads the default timing registers.

module reachability_watchdog_power_cycler (
	input logic clk,
	input logic arst_n,
	rwpc_item_if.sink item,
	rwpc_cfg_if.sink cfg,
	rwpc_result_if.source result
);

	// Configuration registers. Timings are held as tick counts so that the step logic
	// only subtracts timestamps and compares.
	rwpc_pkg::cfg_t cfg_regs;

	// Hand-off between the step stage and the holdoff/output stage.
	logic valid_s2;
	logic ready_s2;
	rwpc_pkg::step_res_t res_s2;

	rwpc_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cfg_regs(cfg_regs)
	);

	// The step stage registers each request, then evaluates the power-cycle sequence,
	// the holdoff expiry and the probe schedule against the watchdog state in one pass.
	// The state is written back on the same edge that passes the request on, so the
	// next request sees it immediately.
	rwpc_step u_step (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cfg_regs(cfg_regs),
		.ready_s2(ready_s2),
		.valid_s2(valid_s2),
		.res_s2(res_s2)
	);

	// The holdoff stage turns the elapsed holdoff ticks into whole seconds remaining,
	// keeps the reported holdoff count and holds the result until it is taken.
	rwpc_holdoff u_holdoff (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_regs(cfg_regs),
		.valid_s2(valid_s2),
		.res_s2(res_s2),
		.ready_s2(ready_s2),
		.result(result)
	);

endmodule
